// ===== design/lrupr_pkg.sv =====
package lrupr_pkg;

  // APB side
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  // register index decoded from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd3;

  localparam int SLOT_OUT_W = 4;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== design/lrupr_ctrl.sv =====
module lrupr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lrupr_pkg::ctrl_cmd_t  cmd
);
  import lrupr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_stall       = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // result word goes out only when the output register is free or draining
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== design/lrupr_dpath.sv =====
module lrupr_dpath #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lrupr_pkg::ctrl_cmd_t              cmd,
  input  logic [lrupr_pkg::CFG_W-1:0]       frames_in_use,
  input  logic [PAGE_BITS-1:0]              page_number,
  input  logic                              last_reference,
  output logic                              page_fault,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0]  frame_slot,
  output logic                              evicted_valid,
  output logic [PAGE_BITS-1:0]              evicted_page,
  output logic [COUNT_BITS-1:0]             fault_total
);
  import lrupr_pkg::*;

  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

  logic [PAGE_BITS-1:0]   resident [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] filled;
  logic [SLOT_W-1:0]      rank [FRAME_SLOTS];
  logic [COUNT_BITS-1:0]  fault_cnt;

  logic [PAGE_BITS-1:0]   page_q;
  logic                   last_q;

  logic [FRAME_SLOTS-1:0] active;
  logic [FRAME_SLOTS-1:0] hit_vec;
  logic [FRAME_SLOTS-1:0] empty_vec;
  logic [FRAME_SLOTS-1:0] lru_vec;
  logic [SLOT_W-1:0]      hit_slot;
  logic [SLOT_W-1:0]      empty_slot;
  logic [SLOT_W-1:0]      lru_slot;
  logic                   any_hit;
  logic                   any_empty;
  logic                   evict;
  logic                   was_filled;
  logic [SLOT_W-1:0]      slot;
  logic [SLOT_W-1:0]      old_rank;
  logic [SLOT_W-1:0]      rank_next [FRAME_SLOTS];
  logic [COUNT_BITS-1:0]  fault_cnt_next;

  always_comb begin
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      // frame 0 always takes part, so a zero count acts as one frame
      active[j]    = (j == 0) || (j < int'(frames_in_use));
      hit_vec[j]   = active[j] && filled[j] && (resident[j] == page_q);
      empty_vec[j] = active[j] && !filled[j];
      // candidate victim: no active frame holds an older rank
      lru_vec[j]   = active[j];
      for (int k = 0; k < FRAME_SLOTS; k++) begin
        if (active[k] && (rank[k] > rank[j])) begin
          lru_vec[j] = 1'b0;
        end
      end
    end

    hit_slot   = '0;
    empty_slot = '0;
    lru_slot   = '0;
    for (int j = FRAME_SLOTS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_slot = SLOT_W'(j);
      end
      if (empty_vec[j]) begin
        empty_slot = SLOT_W'(j);
      end
      if (lru_vec[j]) begin
        lru_slot = SLOT_W'(j);
      end
    end

    any_hit    = |hit_vec;
    any_empty  = |empty_vec;
    evict      = !any_hit && !any_empty;
    was_filled = any_hit || evict;
    slot       = any_hit ? hit_slot : (any_empty ? empty_slot : lru_slot);
    old_rank   = rank[slot];

    for (int j = 0; j < FRAME_SLOTS; j++) begin
      rank_next[j] = rank[j];
      if (SLOT_W'(j) == slot) begin
        rank_next[j] = '0;
      end else if (filled[j] && (!was_filled || (rank[j] < old_rank))) begin
        rank_next[j] = rank[j] + 1'b1;
      end
    end

    if (any_hit || (&fault_cnt)) begin
      fault_cnt_next = fault_cnt;
    end else begin
      fault_cnt_next = fault_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      page_q <= page_number;
      last_q <= last_reference;
    end
    if (cmd.commit) begin
      if (!any_hit) begin
        resident[slot] <= page_q;
      end
      page_fault    <= !any_hit;
      frame_slot    <= SLOT_OUT_W'(slot);
      evicted_valid <= evict;
      evicted_page  <= evict ? resident[slot] : '0;
      fault_total   <= fault_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      fault_cnt <= '0;
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        rank[j] <= '0;
      end
    end else if (cmd.commit) begin
      if (last_q) begin
        // end of string: drop everything after this word is built
        filled    <= '0;
        fault_cnt <= '0;
        for (int j = 0; j < FRAME_SLOTS; j++) begin
          rank[j] <= '0;
        end
      end else begin
        filled[slot] <= 1'b1;
        fault_cnt    <= fault_cnt_next;
        for (int j = 0; j < FRAME_SLOTS; j++) begin
          rank[j] <= rank_next[j];
        end
      end
    end
  end

endmodule

// ===== design/lru_page_replacement.sv =====
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   page_number, last_reference
// out       output     out_valid / out_stall page_fault, frame_slot, evicted_valid,
//                                            evicted_page, fault_total
// cfg       input      APB psel/penable      frames_in_use at byte address 0
//
// Each reference is captured in ST_IDLE; ST_EVAL then does the parallel tag
// compare, victim pick and rank update across all frames and takes no new word.
// A finished result sits in the output register; the next word is taken meanwhile,
// but its evaluation waits while out_stall holds the previous result.
// rst is synchronous: frames empty, ranks and fault count zero, frames_in_use = 3.
module lru_page_replacement #(
  parameter int FRAME_SLOTS = 16,
  parameter int PAGE_BITS   = 8,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PAGE_BITS-1:0]                page_number,
  input  logic                                last_reference,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                page_fault,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0]    frame_slot,
  output logic                                evicted_valid,
  output logic [PAGE_BITS-1:0]                evicted_page,
  output logic [COUNT_BITS-1:0]               fault_total,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrupr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lrupr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0] frames_in_use;
  ctrl_cmd_t        cmd;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_FRAMES_IN_USE);
  assign prdata  = reg_sel ? APB_DATA_W'(frames_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrupr_dpath #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .PAGE_BITS   (PAGE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .frames_in_use  (frames_in_use),
    .page_number    (page_number),
    .last_reference (last_reference),
    .page_fault     (page_fault),
    .frame_slot     (frame_slot),
    .evicted_valid  (evicted_valid),
    .evicted_page   (evicted_page),
    .fault_total    (fault_total)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous one still in evaluation");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> page_fault)
    else $error("eviction reported on a hit");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (frames_in_use > 5'd1)) |-> (CFG_W'(frame_slot) < frames_in_use))
    else $error("frame outside the active set");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  localparam int NUM_FRAMES = 16;
  localparam int PAGE_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int RANDOM_REFS = 1100;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int ERROR_PRINTS = 40;
  localparam logic [APB_ADDR_W-1:0] ADDR_FRAMES = {REG_FRAMES_IN_USE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = {~REG_FRAMES_IN_USE, 2'b00};

  typedef struct {
    logic [PAGE_W-1:0] page;
    logic              last;
  } page_ref_t;

  typedef struct {
    logic                  fault;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  ev_valid;
    logic [PAGE_W-1:0]     ev_page;
    logic [COUNT_W-1:0]    total;
  } lru_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PAGE_W-1:0]     page_number = '0;
  logic                  last_reference = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  page_fault;
  logic [SLOT_OUT_W-1:0] frame_slot;
  logic                  evicted_valid;
  logic [PAGE_W-1:0]     evicted_page;
  logic [COUNT_W-1:0]    fault_total;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_page_replacement uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .page_number(page_number), .last_reference(last_reference),
    .out_valid(out_valid), .out_stall(out_stall),
    .page_fault(page_fault), .frame_slot(frame_slot),
    .evicted_valid(evicted_valid), .evicted_page(evicted_page),
    .fault_total(fault_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the frame table
  logic [PAGE_W-1:0]  held_page [NUM_FRAMES];
  bit                 held [NUM_FRAMES];
  logic [3:0]         age_rank [NUM_FRAMES];
  logic [COUNT_W-1:0] faults = '0;
  logic [CFG_W-1:0]   frame_reg = FRAMES_RESET;

  page_ref_t    ref_q[$];
  lru_outcome_t due_results[$];

  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int results_seen = 0;
  int faults_seen = 0;
  int evictions_seen = 0;
  int cfg_writes = 0;
  int cycles = 0;

  initial begin
    foreach (held[j]) begin
      held[j] = 1'b0;
      age_rank[j] = '0;
      held_page[j] = '0;
    end
  end

  function automatic int clamp_frames(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > NUM_FRAMES) return NUM_FRAMES;
    return int'(v);
  endfunction

  // make frame s the most recent; filled frames newer than it age by one (all filled frames if s was empty)
  function automatic void promote(int s, bit was_filled);
    logic [3:0] old;
    old = age_rank[s];
    for (int j = 0; j < NUM_FRAMES; j++) begin
      if (j != s && held[j] && (!was_filled || age_rank[j] < old))
        age_rank[j]++;
    end
    age_rank[s] = '0;
    held[s] = 1'b1;
  endfunction

  function automatic lru_outcome_t lookup_page(logic [PAGE_W-1:0] pg, logic last);
    lru_outcome_t o;
    int n;
    int slot;
    bit hit;
    bit empty_found;
    o = '{default: '0};
    n = clamp_frames(frame_reg);
    hit = 1'b0;
    empty_found = 1'b0;
    slot = 0;
    for (int j = 0; j < n; j++) begin
      if (!hit && held[j] && held_page[j] == pg) begin
        hit = 1'b1;
        slot = j;
      end
    end
    if (hit) begin
      promote(slot, 1'b1);
    end else begin
      o.fault = 1'b1;
      if (faults != '1) faults++;
      for (int j = 0; j < n; j++) begin
        if (!empty_found && !held[j]) begin
          empty_found = 1'b1;
          slot = j;
        end
      end
      if (empty_found) begin
        held_page[slot] = pg;
        promote(slot, 1'b0);
      end else begin
        slot = 0;
        for (int j = 1; j < n; j++)
          if (age_rank[j] > age_rank[slot]) slot = j;
        o.ev_valid = 1'b1;
        o.ev_page = held_page[slot];
        held_page[slot] = pg;
        promote(slot, 1'b1);
      end
    end
    o.slot = slot[SLOT_OUT_W-1:0];
    o.total = faults;
    if (last) begin
      foreach (held[j]) begin
        held[j] = 1'b0;
        age_rank[j] = '0;
        held_page[j] = '0;
      end
      faults = '0;
    end
    return o;
  endfunction

  // mostly short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_ref(logic [PAGE_W-1:0] p, logic l);
    page_ref_t r;
    r.page = p;
    r.last = l;
    ref_q.push_back(r);
  endfunction

  function automatic void report_field(string name, int expv, int got);
    if (expv != got) begin
      mismatches++;
      if (mismatches <= ERROR_PRINTS)
        $error("%s: expected %0d, got %0d", name, expv, got);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    page_ref_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        due_results.push_back(lookup_page(page_number, last_reference));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (ref_q.size() > 0) begin
          nxt = ref_q.pop_front();
          page_number <= nxt.page;
          last_reference <= nxt.last;
          in_valid <= 1'b1;
          gap_left <= quiet ? 0 : draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    lru_outcome_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $error("result word with nothing expected: frame_slot %0d", frame_slot);
        end else begin
          want = due_results.pop_front();
          results_seen++;
          if (want.fault) faults_seen++;
          if (want.ev_valid) evictions_seen++;
          report_field("page_fault", want.fault, page_fault);
          report_field("frame_slot", want.slot, frame_slot);
          report_field("evicted_valid", want.ev_valid, evicted_valid);
          report_field("evicted_page", want.ev_page, evicted_page);
          report_field("fault_total", want.total, fault_total);
        end
      end
      if (quiet) begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_page_replacement regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (ref_q.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_FRAMES_IN_USE) frame_reg = data[CFG_W-1:0];
    cfg_writes++;
  endtask

  initial begin
    int random_refs;
    int n_eff;
    int len;
    int r;
    logic [CFG_W-1:0] fsel;
    logic [APB_DATA_W-1:0] wdata;
    logic [PAGE_W-1:0] pool[$];
    logic [PAGE_W-1:0] pg;
    logic lastbit;

    random_refs = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset count of three: fill, hit, evict the oldest, end the string
    push_ref(8'd0, 1'b0);
    push_ref(8'd255, 1'b0);
    push_ref(8'd0, 1'b0);
    push_ref(8'hAA, 1'b0);
    push_ref(8'h55, 1'b0);
    push_ref(8'd0, 1'b0);
    push_ref(8'd255, 1'b1);
    wait_drained();

    // count zero behaves as one frame
    cfg_write(ADDR_FRAMES, 32'd0);
    push_ref(8'd1, 1'b0);
    push_ref(8'd1, 1'b0);
    push_ref(8'd2, 1'b0);
    push_ref(8'd1, 1'b1);
    wait_drained();

    // writes to other addresses change nothing
    cfg_write(ADDR_UNUSED, 32'd5);
    push_ref(8'd128, 1'b0);
    push_ref(8'd127, 1'b1);
    wait_drained();

    // shrink mid-string: the page in frame four gets a second copy in frame zero
    cfg_write(ADDR_FRAMES, 32'd16);
    for (int i = 10; i < 15; i++) push_ref(i[PAGE_W-1:0], 1'b0);
    wait_drained();
    cfg_write(ADDR_FRAMES, 32'd2);
    push_ref(8'd14, 1'b0);
    wait_drained();
    cfg_write(ADDR_FRAMES, 32'd31);
    push_ref(8'd14, 1'b0);
    push_ref(8'd12, 1'b1);
    wait_drained();

    while (random_refs < RANDOM_REFS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: fsel = 5'd0;
        1: fsel = 5'd1;
        2: fsel = 5'd16;
        3: fsel = 5'd31;
        4: fsel = CFG_W'($urandom_range(17, 30));
        default: fsel = CFG_W'($urandom_range(2, 15));
      endcase
      wdata = {{(APB_DATA_W-CFG_W){1'b0}}, fsel};
      if ($urandom_range(0, 3) == 0)
        wdata = ($urandom & ~32'h1F) | wdata;
      cfg_write(ADDR_FRAMES, wdata);
      if ($urandom_range(0, 5) == 0) cfg_write(ADDR_UNUSED, $urandom);
      quiet = ($urandom_range(0, 4) == 0);
      n_eff = clamp_frames(frame_reg);
      pool.delete();
      repeat (n_eff + $urandom_range(0, 3)) pool.push_back(PAGE_W'($urandom_range(0, 255)));
      len = $urandom_range(10, 120);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 80) pg = pool[$urandom_range(0, pool.size() - 1)];
        else if (r < 92) pg = PAGE_W'($urandom_range(0, 255));
        else pg = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        lastbit = ($urandom_range(0, 49) == 0);
        if (i == len - 1 && $urandom_range(0, 2) == 0) lastbit = 1'b1;
        push_ref(pg, lastbit);
        random_refs++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("%0d result words checked: %0d faults, %0d evictions",
             results_seen, faults_seen, evictions_seen);
    $display("%0d register writes, %0d random references across frame counts 1..16",
             cfg_writes, random_refs);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("lru_page_replacement regression: pass");
    end else begin
      $display("lru_page_replacement regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lrupr_pkg.sv
design/lrupr_ctrl.sv
design/lrupr_dpath.sv
design/lru_page_replacement.sv
tb/sv/tb.sv
